// File: rtl/jstp_pkg.sv
// Shared types, constants and character tables for the JSON scalar token parser.
package jstp_pkg;

	// parse phase of the open token
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_NUM  = 2'd1,
		PH_BOOL = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	// expected token kind
	typedef enum logic [1:0] {
		KIND_SIGNED   = 2'd0,
		KIND_UNSIGNED = 2'd1,
		KIND_BOOL     = 2'd2,
		KIND_BAD      = 2'd3
	} kind_t;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_F     = 8'h66;

	localparam int unsigned NEXT_W = 36;
	localparam logic [NEXT_W-1:0] LIMIT_POS = 36'd2147483647;
	localparam logic [NEXT_W-1:0] LIMIT_NEG = 36'd2147483648;
	localparam logic [NEXT_W-1:0] LIMIT_U   = 36'hFFFFFFFF;

	localparam logic [3:0] LEN_TRUE  = 4'd4;
	localparam logic [3:0] LEN_FALSE = 4'd5;

	// one input item
	typedef struct packed {
		logic [7:0] ch;
		logic       start;
		logic       last;
		logic [1:0] kind;
	} item_t;

	// parser state carried from item to item
	typedef struct packed {
		phase_t      phase;
		logic [31:0] accum;
		logic        neg;
		logic [3:0]  count;
		logic [1:0]  kind;
		logic        lz;
	} state_t;

	// one result item
	typedef struct packed {
		logic        ok;
		logic [31:0] value;
		logic [3:0]  consumed;
	} res_t;

	// expected letter of "true" or "false" at a position
	function automatic logic [7:0] want_char(input logic is_false, input logic [3:0] idx);
		logic [7:0] c;
		c = 8'h00;
		if (is_false) begin
			unique case (idx)
				4'd0: c = 8'h66;
				4'd1: c = 8'h61;
				4'd2: c = 8'h6C;
				4'd3: c = 8'h73;
				4'd4: c = 8'h65;
				default: c = 8'h00;
			endcase
		end else begin
			unique case (idx)
				4'd0: c = 8'h74;
				4'd1: c = 8'h72;
				4'd2: c = 8'h75;
				4'd3: c = 8'h65;
				default: c = 8'h00;
			endcase
		end
		return c;
	endfunction

endpackage

// File: rtl/jstp_step.sv
// Next-state and result logic for one character of a token span.
module jstp_step (
	input  jstp_pkg::state_t st,
	input  jstp_pkg::item_t  item,
	output jstp_pkg::state_t nxt,
	output logic             res_valid,
	output jstp_pkg::res_t   res
);
	import jstp_pkg::*;

	state_t            w;
	logic              digit;
	logic [3:0]        d;
	logic [3:0]        ndig;
	logic [NEXT_W-1:0] next_val;
	logic [NEXT_W-1:0] limit;
	logic [3:0]        len;
	logic [3:0]        cnt_inc;

	always_comb begin
		// clear the working state on a span start
		w = st;
		if (item.start) begin
			w.accum = '0;
			w.neg   = 1'b0;
			w.count = '0;
			w.lz    = 1'b0;
			w.kind  = item.kind;
			priority case (kind_t'(item.kind))
				KIND_BOOL: w.phase = PH_BOOL;
				KIND_BAD:  w.phase = PH_DONE;
				default:   w.phase = PH_NUM;
			endcase
		end

		digit    = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
		d        = digit ? item.ch[3:0] : 4'd0;
		ndig     = w.count - {3'b0, w.neg};
		next_val = ({4'b0, w.accum} << 3) + ({4'b0, w.accum} << 1) + {32'b0, d};
		if (kind_t'(w.kind) == KIND_SIGNED) begin
			limit = w.neg ? LIMIT_NEG : LIMIT_POS;
		end else begin
			limit = LIMIT_U;
		end
		len     = LEN_TRUE;
		cnt_inc = w.count + 4'd1;

		nxt       = w;
		res_valid = 1'b0;
		res       = '0;

		if (item.start && kind_t'(item.kind) == KIND_BAD) begin
			// unknown kind fails at the start character
			res_valid = 1'b1;
		end else if (w.phase == PH_NUM) begin
			if (ndig == 4'd0) begin
				if (w.count == 4'd0 && kind_t'(w.kind) == KIND_SIGNED && item.ch == CH_MINUS) begin
					nxt.neg   = 1'b1;
					nxt.count = 4'd1;
					if (item.last) begin
						nxt.phase = PH_DONE;
						res_valid = 1'b1;
					end
				end else if (!digit) begin
					nxt.phase = PH_DONE;
					res_valid = 1'b1;
				end else begin
					if (d == 4'd0) nxt.lz = 1'b1;
					nxt.accum = {28'b0, d};
					nxt.count = cnt_inc;
					if (item.last) begin
						nxt.phase    = PH_DONE;
						res_valid    = 1'b1;
						res.ok       = 1'b1;
						res.value    = w.neg ? (~{28'b0, d} + 32'd1) : {28'b0, d};
						res.consumed = cnt_inc;
					end
				end
			end else if (!digit) begin
				// terminator ends the number
				nxt.phase    = PH_DONE;
				res_valid    = 1'b1;
				res.ok       = 1'b1;
				res.value    = w.neg ? (~w.accum + 32'd1) : w.accum;
				res.consumed = w.count;
			end else if (w.lz || next_val > limit) begin
				nxt.phase = PH_DONE;
				res_valid = 1'b1;
			end else begin
				nxt.accum = next_val[31:0];
				nxt.count = cnt_inc;
				if (item.last) begin
					nxt.phase    = PH_DONE;
					res_valid    = 1'b1;
					res.ok       = 1'b1;
					res.value    = w.neg ? (~next_val[31:0] + 32'd1) : next_val[31:0];
					res.consumed = cnt_inc;
				end
			end
		end else if (w.phase == PH_BOOL) begin
			// pick the word on the first letter
			if (w.count == 4'd0) begin
				if (item.ch == CH_T) begin
					nxt.neg = 1'b0;
				end else if (item.ch == CH_F) begin
					nxt.neg = 1'b1;
				end
			end
			len = nxt.neg ? LEN_FALSE : LEN_TRUE;
			if ((w.count == 4'd0 && item.ch != CH_T && item.ch != CH_F)
				|| w.count >= len || item.ch != want_char(nxt.neg, w.count)) begin
				nxt.phase = PH_DONE;
				res_valid = 1'b1;
			end else begin
				nxt.count = cnt_inc;
				if (cnt_inc == len) begin
					nxt.phase    = PH_DONE;
					res_valid    = 1'b1;
					res.ok       = 1'b1;
					res.value    = {31'b0, ~nxt.neg};
					res.consumed = len;
				end else if (item.last) begin
					nxt.phase = PH_DONE;
					res_valid = 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/json_scalar_token_parser_unit.sv
// Top level of the JSON scalar token parser: input stage, parser state and output skid.
//
// Characters of a token span enter on the s_axis channel, one per item. tuser carries
// the span start flag and the expected kind (signed int, unsigned int, boolean); tlast
// marks the last character available. A span start clears the parser and latches the kind.
// One result leaves on the m_axis channel when the token ends: ok in tuser, the 32-bit
// value and the consumed character count in tdata. A failure gives ok 0, value 0, count 0.
// Characters after the end of a token give no result until the next span start.
// Throughput is one character per cycle while the skid entry is empty. An accepted
// character is held in the input stage, decoded against the parser state, and its
// result, if any, is registered in the output register or the skid entry for m_axis.
// When the receiver stalls, a second output entry takes one more result; with both
// entries full the input stage holds and, when full, drops s_axis_tready. tready depends only on
// registers. Reset clears the parser to idle and empties all stages; no span is open.
module json_scalar_token_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] ch
	input  logic [2:0]  s_axis_tuser,  // [0] token_start, [2:1] kind
	input  logic        s_axis_tlast,  // span_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] value_bits, [35:32] consumed, rest zero
	output logic        m_axis_tuser   // ok
);
	import jstp_pkg::*;

	item_t  item_s1;
	logic   in_valid_s1;
	state_t state_q;
	state_t state_nxt;
	logic   res_valid;
	res_t   res;
	res_t   out_q;
	logic   out_valid_q;
	res_t   skid_q;
	logic   skid_valid_q;
	logic   advance;
	logic   push;
	logic   pop;

	assign advance       = in_valid_s1 && !skid_valid_q;
	assign s_axis_tready = !in_valid_s1 || !skid_valid_q;
	assign push          = advance && res_valid;
	assign pop           = out_valid_q && m_axis_tready;

	jstp_step u_step (
		.st        (state_q),
		.item      (item_s1),
		.nxt       (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	// capture an input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.ch    <= s_axis_tdata;
			item_s1.start <= s_axis_tuser[0];
			item_s1.last  <= s_axis_tlast;
			item_s1.kind  <= s_axis_tuser[2:1];
		end
	end

	// advance the parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, accum: '0, neg: 1'b0, count: '0, kind: '0, lz: 1'b0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.ok;
	assign m_axis_tdata  = {4'b0, out_q.consumed, out_q.value};

endmodule
